FILE: design/trd_pkg.sv
// shared types and constants of the tilt rotation detector
package trd_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_ROTATION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_THRESHOLD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_TIME     = 3'd4;

	// register widths and reset values
	localparam int THR_W    = 15;
	localparam int ALPHA_W  = 9;
	localparam int STABLE_W = 16;
	localparam int TIME_W   = 32;

	localparam logic [THR_W-1:0]    THR_RESET    = 15'd2048;
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 9'd90;
	localparam logic [STABLE_W-1:0] STABLE_RESET = 16'd350;

	// rotation quadrants
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// classifier result handed to the debouncer
	typedef struct packed {
		logic              tilted;
		logic [1:0]        target;
		logic [TIME_W-1:0] now;
	} quad_info_t;

	// register writes that touch the debounce state
	typedef struct packed {
		logic       set_auto;
		logic       auto_val;
		logic       set_manual;
		logic [1:0] rot;
	} dbc_cmd_t;

endpackage

FILE: design/trd_intf.sv
// channel interfaces: sample in, result out, configuration writes
interface trd_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;
	logic [31:0]                   now_ms;

	modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

interface trd_result_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    rotation;
	logic                          rotation_changed;
	logic                          tilted;
	logic signed [SAMPLE_BITS-1:0] filtered_x;
	logic signed [SAMPLE_BITS-1:0] filtered_y;
	logic signed [SAMPLE_BITS-1:0] filtered_z;

	modport source (output valid, rotation, rotation_changed, tilted,
		filtered_x, filtered_y, filtered_z, input ready);
	modport sink   (input valid, rotation, rotation_changed, tilted,
		filtered_x, filtered_y, filtered_z, output ready);
endinterface

interface trd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/trd_lane.sv
// one axis of the exponential filter
module trd_lane
	import trd_pkg::*;
#(
	parameter int SAMPLE_BITS     = 16,
	parameter int ALPHA_FRAC_BITS = 8,
	parameter int ALPHA_EFF_W     = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          first,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [ALPHA_EFF_W-1:0]        alpha,
	output logic signed [SAMPLE_BITS-1:0] filt
);

	localparam int PW = SAMPLE_BITS + ALPHA_EFF_W + 2;

	logic signed [SAMPLE_BITS-1:0] filt_q;
	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          step;
	logic signed [SAMPLE_BITS-1:0] next_filt;

	always_comb begin
		diff      = {sample[SAMPLE_BITS-1], sample} - {filt_q[SAMPLE_BITS-1], filt_q};
		prod      = $signed({{(PW-SAMPLE_BITS-1){diff[SAMPLE_BITS]}}, diff})
			* $signed({{(PW-ALPHA_EFF_W){1'b0}}, alpha});
		// floor shift
		step      = prod >>> ALPHA_FRAC_BITS;
		next_filt = filt_q + step[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (load) begin
			filt_q <= first ? sample : next_filt;
		end
	end

	assign filt = filt_q;

endmodule

FILE: design/trd_quadrant.sv
// merge stage: tilt test and quadrant pick from filtered x and y
module trd_quadrant
	import trd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] fx,
	input  logic signed [SAMPLE_BITS-1:0] fy,
	input  logic signed [SAMPLE_BITS-1:0] fz,
	input  logic [TIME_W-1:0]             now,
	input  logic [THR_W-1:0]              threshold,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] fx_out,
	output logic signed [SAMPLE_BITS-1:0] fy_out,
	output logic signed [SAMPLE_BITS-1:0] fz_out,
	output quad_info_t                    info
);

	localparam int CW = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	logic [SAMPLE_BITS-1:0]        ax;
	logic [SAMPLE_BITS-1:0]        ay;
	logic [CW-1:0]                 axw;
	logic [CW-1:0]                 ayw;
	logic [CW-1:0]                 thrw;
	quad_info_t                    info_d;
	logic                          valid_s2;
	quad_info_t                    info_s2;
	logic signed [SAMPLE_BITS-1:0] fx_s2;
	logic signed [SAMPLE_BITS-1:0] fy_s2;
	logic signed [SAMPLE_BITS-1:0] fz_s2;

	always_comb begin
		ax   = fx[SAMPLE_BITS-1] ? -fx : fx;
		ay   = fy[SAMPLE_BITS-1] ? -fy : fy;
		axw  = CW'(ax);
		ayw  = CW'(ay);
		thrw = CW'(threshold);
		info_d.tilted = (axw >= thrw) || (ayw >= thrw);
		info_d.now    = now;
		info_d.target = ROT_0;
		if (info_d.tilted) begin
			if (ayw > axw) begin
				info_d.target = (!fy[SAMPLE_BITS-1] && fy != '0) ? ROT_270 : ROT_90;
			end else begin
				info_d.target = (!fx[SAMPLE_BITS-1] && fx != '0) ? ROT_0 : ROT_180;
			end
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			info_s2 <= info_d;
			fx_s2   <= fx;
			fy_s2   <= fy;
			fz_s2   <= fz;
		end
	end

	assign out_valid = valid_s2;
	assign info      = info_s2;
	assign fx_out    = fx_s2;
	assign fy_out    = fy_s2;
	assign fz_out    = fz_s2;

endmodule

FILE: design/trd_debounce.sv
// rotation debounce state and result register
module trd_debounce
	import trd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dbc_cmd_t                      cmd,
	input  logic [STABLE_W-1:0]           stable_time,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  quad_info_t                    info,
	input  logic signed [SAMPLE_BITS-1:0] fx,
	input  logic signed [SAMPLE_BITS-1:0] fy,
	input  logic signed [SAMPLE_BITS-1:0] fz,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    rotation,
	output logic                          rotation_changed,
	output logic                          tilted,
	output logic signed [SAMPLE_BITS-1:0] filtered_x,
	output logic signed [SAMPLE_BITS-1:0] filtered_y,
	output logic signed [SAMPLE_BITS-1:0] filtered_z
);

	logic                          auto_q;
	logic [1:0]                    cur_q;
	logic [1:0]                    cand_q;
	logic [TIME_W-1:0]             start_q;
	logic                          valid_s3;
	logic [1:0]                    rot_s3;
	logic                          changed_s3;
	logic                          tilted_s3;
	logic signed [SAMPLE_BITS-1:0] fx_s3;
	logic signed [SAMPLE_BITS-1:0] fy_s3;
	logic signed [SAMPLE_BITS-1:0] fz_s3;
	logic                          take;
	logic [TIME_W-1:0]             elapsed;
	logic                          settle;
	logic                          restart;
	logic                          new_cand;

	assign in_ready = !valid_s3 || out_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		elapsed  = info.now - start_q;
		restart  = !info.tilted || info.target == cur_q;
		new_cand = !restart && info.target != cand_q;
		settle   = auto_q && !restart && !new_cand
			&& elapsed >= TIME_W'(stable_time);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q   <= 1'b1;
			cur_q    <= ROT_0;
			cand_q   <= ROT_0;
			start_q  <= '0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (cmd.set_manual) begin
				auto_q <= 1'b0;
				cur_q  <= cmd.rot;
				cand_q <= cmd.rot;
			end else if (cmd.set_auto) begin
				auto_q <= cmd.auto_val;
				cand_q <= cur_q;
			end else if (take && auto_q) begin
				if (restart) begin
					cand_q  <= cur_q;
					start_q <= info.now;
				end else if (new_cand) begin
					cand_q  <= info.target;
					start_q <= info.now;
				end else if (settle) begin
					cur_q <= info.target;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rot_s3     <= settle ? info.target : cur_q;
			changed_s3 <= settle;
			tilted_s3  <= info.tilted;
			fx_s3      <= fx;
			fy_s3      <= fy;
			fz_s3      <= fz;
		end
	end

	assign out_valid        = valid_s3;
	assign rotation         = rot_s3;
	assign rotation_changed = changed_s3;
	assign tilted           = tilted_s3;
	assign filtered_x       = fx_s3;
	assign filtered_y       = fy_s3;
	assign filtered_z       = fz_s3;

endmodule

FILE: design/tilt_rotation_detector.sv
// tilt rotation detector top level: filter lanes, quadrant merge, debounce
// Takes one accelerometer sample (Q4.12 g per axis, millisecond timestamp) per
// transfer and returns one result per sample: the debounced screen rotation,
// a flag for the sample that switched it, the tilt flag and the filtered axes.
// A new sample can be taken every clock cycle while results are taken. Each
// result is registered through the filter lanes, the quadrant stage and the
// debounce stage before it is offered. The rate is set by the filter recurrence,
// which closes without a register through each lane's subtract, multiply and
// add. Each stage holds its item while the next one is full, so the sample side
// keeps taking transfers while a result waits until all three stages hold an
// item, then stalls until the result is taken. Configuration writes are taken
// every cycle and should only be issued with the pipeline empty.
module tilt_rotation_detector
	import trd_pkg::*;
#(
	parameter int SAMPLE_BITS     = 16,
	parameter int ALPHA_FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	trd_sample_if.sink   smp,
	trd_result_if.source res,
	trd_cfg_if.sink      cfg
);

	// alpha wide enough for the register and for exactly one
	localparam int ALPHA_EFF_W = (ALPHA_FRAC_BITS + 1 > ALPHA_W) ? ALPHA_FRAC_BITS + 1 : ALPHA_W;
	localparam logic [ALPHA_EFF_W-1:0] ALPHA_ONE = ALPHA_EFF_W'(1) << ALPHA_FRAC_BITS;

	// configuration registers
	logic [THR_W-1:0]    thr_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [STABLE_W-1:0] stable_q;
	logic                cfg_wr;
	dbc_cmd_t            cmd;

	// filter and stage one
	logic                          loaded_q;
	logic                          valid_s1;
	logic [TIME_W-1:0]             now_s1;
	logic                          ready_s1;
	logic                          take_s1;
	logic [ALPHA_EFF_W-1:0]        alpha_ext;
	logic [ALPHA_EFF_W-1:0]        alpha_eff;
	logic signed [SAMPLE_BITS-1:0] fx_s1;
	logic signed [SAMPLE_BITS-1:0] fy_s1;
	logic signed [SAMPLE_BITS-1:0] fz_s1;

	// stage two to stage three
	logic                          q_ready;
	logic                          q_valid;
	logic                          d_ready;
	quad_info_t                    q_info;
	logic signed [SAMPLE_BITS-1:0] fx_s2;
	logic signed [SAMPLE_BITS-1:0] fy_s2;
	logic signed [SAMPLE_BITS-1:0] fz_s2;

	// configuration write port, always ready
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			alpha_q  <= ALPHA_RESET;
			stable_q <= STABLE_RESET;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_TILT_THRESHOLD: begin
					thr_q <= cfg.data[THR_W-1:0];
				end
				REG_FILTER_ALPHA: begin
					alpha_q <= cfg.data[ALPHA_W-1:0];
				end
				REG_STABLE_TIME: begin
					stable_q <= cfg.data[STABLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// writes that act on the debounce state directly
	always_comb begin
		cmd.set_auto   = cfg_wr && cfg.index == REG_AUTO_ENABLE;
		cmd.auto_val   = cfg.data[0];
		cmd.set_manual = cfg_wr && cfg.index == REG_MANUAL_ROTATION;
		cmd.rot        = cfg.data[1:0];
	end

	// alpha above one saturates to one
	always_comb begin
		alpha_ext = ALPHA_EFF_W'(alpha_q);
		alpha_eff = (alpha_ext > ALPHA_ONE) ? ALPHA_ONE : alpha_ext;
	end

	// stage one: the lane registers are both filter state and stage payload
	assign ready_s1  = !valid_s1 || q_ready;
	assign smp.ready = ready_s1;
	assign take_s1   = smp.valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			loaded_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= smp.valid;
			end
			if (take_s1) begin
				loaded_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			now_s1 <= smp.now_ms;
		end
	end

	trd_lane #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.ALPHA_FRAC_BITS (ALPHA_FRAC_BITS),
		.ALPHA_EFF_W     (ALPHA_EFF_W)
	) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take_s1),
		.first  (!loaded_q),
		.sample (smp.accel_x),
		.alpha  (alpha_eff),
		.filt   (fx_s1)
	);

	trd_lane #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.ALPHA_FRAC_BITS (ALPHA_FRAC_BITS),
		.ALPHA_EFF_W     (ALPHA_EFF_W)
	) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take_s1),
		.first  (!loaded_q),
		.sample (smp.accel_y),
		.alpha  (alpha_eff),
		.filt   (fy_s1)
	);

	// z is filtered only, it takes no part in the quadrant
	trd_lane #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.ALPHA_FRAC_BITS (ALPHA_FRAC_BITS),
		.ALPHA_EFF_W     (ALPHA_EFF_W)
	) u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take_s1),
		.first  (!loaded_q),
		.sample (smp.accel_z),
		.alpha  (alpha_eff),
		.filt   (fz_s1)
	);

	// stage two: merge x and y into a tilt flag and target quadrant
	trd_quadrant #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_quadrant (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (q_ready),
		.fx        (fx_s1),
		.fy        (fy_s1),
		.fz        (fz_s1),
		.now       (now_s1),
		.threshold (thr_q),
		.out_valid (q_valid),
		.out_ready (d_ready),
		.fx_out    (fx_s2),
		.fy_out    (fy_s2),
		.fz_out    (fz_s2),
		.info      (q_info)
	);

	// stage three: candidate timing and the result register
	trd_debounce #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_debounce (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stable_time      (stable_q),
		.in_valid         (q_valid),
		.in_ready         (d_ready),
		.info             (q_info),
		.fx               (fx_s2),
		.fy               (fy_s2),
		.fz               (fz_s2),
		.out_valid        (res.valid),
		.out_ready        (res.ready),
		.rotation         (res.rotation),
		.rotation_changed (res.rotation_changed),
		.tilted           (res.tilted),
		.filtered_x       (res.filtered_x),
		.filtered_y       (res.filtered_y),
		.filtered_z       (res.filtered_z)
	);

endmodule

FILE: sim/tb_tilt_rotation_detector.sv
`timescale 1ns / 1ps
// testbench of the tilt rotation detector: directed and random samples checked against a local predictor
module tb_tilt_rotation_detector;
	import trd_pkg::*;

	localparam int SB           = 16;
	localparam int AFB          = 8;
	localparam int ONE_G        = 4096;      // 1 g in Q4.12
	localparam int LIMIT_CYCLES = 200000;    // limit for the watchdog
	localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
	localparam int MAX_SHOWN    = 10;
	localparam int END_CYCLES   = 16;        // three-stage pipeline, plenty of margin
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 42;
	// indexes past the register list, writes there must do nothing
	localparam int FIRST_SPARE_REG = 5;
	localparam int LAST_SPARE_REG  = 7;

	typedef logic signed [SB-1:0] sample_t;

	// one result as the block reports it
	typedef struct packed {
		logic [1:0] rotation;
		logic       changed;
		logic       tilted;
		sample_t    fx;
		sample_t    fy;
		sample_t    fz;
	} orient_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	trd_sample_if #(.SAMPLE_BITS(SB)) smp ();
	trd_result_if #(.SAMPLE_BITS(SB)) res ();
	trd_cfg_if                        cfg ();

	tilt_rotation_detector #(
		.SAMPLE_BITS     (SB),
		.ALPHA_FRAC_BITS (AFB)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.res    (res),
		.cfg    (cfg)
	);

	// ------------------------------------------------------------------
	// predictor state: filter, debounce and a copy of the registers
	// ------------------------------------------------------------------
	sample_t              filt_x, filt_y, filt_z;
	bit                   filt_loaded;
	logic [1:0]           cur_quad, cand_quad;
	logic [31:0]          cand_since;
	bit                   auto_on;
	logic [1:0]           manual_rot;
	logic [THR_W-1:0]     threshold;
	logic [ALPHA_W-1:0]   alpha;
	logic [STABLE_W-1:0]  hold_ms;

	orient_t    pending[$];     // expected results, oldest first
	reg_write_t reg_plan[$];    // register writes waiting for the next idle window

	int          mismatches;
	int          cycle_count;
	int          samples_sent;
	logic [31:0] ms_now;        // running timestamp of the random traffic

	// sender pacing
	bit pacing_on;
	int burst_left;

	// receiver hold-off request, counted down in the receiver process
	bit hold_go;
	int hold_left;
	int stall_pct;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// register write as the block applies it, only the low bits count
	function automatic void apply_reg(reg_write_t w);
		case (w.idx)
			REG_AUTO_ENABLE: begin
				auto_on   = w.data[0];
				cand_quad = cur_quad;
			end
			REG_MANUAL_ROTATION: begin
				manual_rot = w.data[1:0];
				auto_on    = 1'b0;
				cur_quad   = w.data[1:0];
				cand_quad  = w.data[1:0];
			end
			REG_TILT_THRESHOLD: threshold = w.data[THR_W-1:0];
			REG_FILTER_ALPHA:   alpha     = w.data[ALPHA_W-1:0];
			REG_STABLE_TIME:    hold_ms   = w.data[STABLE_W-1:0];
			default: ;
		endcase
	endfunction

	// one filter lane: move towards the sample, the shift floors
	function automatic sample_t smooth(sample_t f, sample_t s, longint gain);
		longint nudge;
		nudge = (gain * (longint'(s) - longint'(f))) >>> AFB;
		return sample_t'(longint'(f) + nudge);
	endfunction

	// advances the predictor by one sample and returns the expected result
	function automatic orient_t track_orientation(sample_t x, sample_t y, sample_t z,
			logic [31:0] stamp);
		longint      gain;
		longint      ax, ay;
		logic [1:0]  aim;
		logic [31:0] elapsed;
		orient_t     r;
		// alpha above one saturates to exactly one
		gain = longint'(alpha);
		if (gain > (longint'(1) << AFB))
			gain = longint'(1) << AFB;
		if (!filt_loaded) begin
			filt_x      = x;
			filt_y      = y;
			filt_z      = z;
			filt_loaded = 1'b1;
		end else begin
			filt_x = smooth(filt_x, x, gain);
			filt_y = smooth(filt_y, y, gain);
			filt_z = smooth(filt_z, z, gain);
		end
		ax = longint'(filt_x);
		ay = longint'(filt_y);
		if (ax < 0)
			ax = -ax;
		if (ay < 0)
			ay = -ay;
		r.tilted = !(ax < longint'(threshold) && ay < longint'(threshold));
		// y must strictly dominate, on a tie x decides; zero x is not positive
		aim = ROT_0;
		if (r.tilted) begin
			if (ay > ax)
				aim = (filt_y > 0) ? ROT_270 : ROT_90;
			else
				aim = (filt_x > 0) ? ROT_0 : ROT_180;
		end
		r.changed = 1'b0;
		if (auto_on) begin
			elapsed = stamp - cand_since;
			if (!r.tilted || aim == cur_quad) begin
				cand_quad  = cur_quad;
				cand_since = stamp;
			end else if (aim != cand_quad) begin
				cand_quad  = aim;
				cand_since = stamp;
			end else if (elapsed >= 32'(hold_ms)) begin
				cur_quad  = aim;
				r.changed = 1'b1;
			end
		end
		r.rotation = cur_quad;
		r.fx       = filt_x;
		r.fy       = filt_y;
		r.fz       = filt_z;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// sample sender
	// ------------------------------------------------------------------

	// random bursts and gaps; valid stays high inside a burst
	task automatic pace_sender();
		if (!pacing_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
		smp.valid <= 1'b0;
		repeat ($urandom_range(1, 8)) @(posedge clk);
	endtask

	// offers one sample, predicts it at the transfer, then paces
	task automatic send_sample(input sample_t x, input sample_t y, input sample_t z,
			input logic [31:0] stamp);
		smp.valid   <= 1'b1;
		smp.accel_x <= x;
		smp.accel_y <= y;
		smp.accel_z <= z;
		smp.now_ms  <= stamp;
		do @(posedge clk); while (smp.ready !== 1'b1);
		pending.push_back(track_orientation(x, y, z, stamp));
		samples_sent++;
		pace_sender();
	endtask

	// stop offering and wait until every expected result has been seen
	task automatic settle();
		smp.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// configuration writes, only issued with the pipeline empty
	// ------------------------------------------------------------------

	task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		reg_write_t w;
		w.idx  = idx;
		w.data = data;
		reg_plan.push_back(w);
	endtask

	// valid stays high across back-to-back writes and drops after the last one
	task automatic commit_regs();
		reg_write_t w;
		while (reg_plan.size() != 0) begin
			w = reg_plan.pop_front();
			cfg.valid <= 1'b1;
			cfg.index <= w.idx;
			cfg.data  <= w.data;
			do @(posedge clk); while (cfg.ready !== 1'b1);
			apply_reg(w);
		end
		cfg.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// a run of samples with gravity mostly along one screen direction
	task automatic lean_run(input logic [1:0] quad, input int count, input int max_dt);
		int major, minor, vx, vy, vz;
		repeat (count) begin
			major = 3300 + int'($urandom_range(0, 1600));
			minor = int'($urandom_range(0, 3000)) - 1500;
			vz    = int'($urandom_range(0, 2 * ONE_G)) - ONE_G;
			case (quad)
				ROT_0:   begin vx =  major; vy =  minor; end
				ROT_180: begin vx = -major; vy =  minor; end
				ROT_270: begin vx =  minor; vy =  major; end
				default: begin vx =  minor; vy = -major; end
			endcase
			ms_now += $urandom_range(0, max_dt);
			send_sample(sample_t'(vx), sample_t'(vy), sample_t'(vz), ms_now);
		end
	endtask

	// fully random sample, now and then with a jump anywhere in time
	task automatic noise_sample();
		if ($urandom_range(0, 3) == 0)
			ms_now = $urandom;
		else
			ms_now += $urandom_range(0, 400);
		send_sample(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom), ms_now);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// first sample loads the filter, later ones follow it; alpha above one and zero
	task automatic test_filter_load();
		send_sample(sample_t'(-32768), sample_t'(32767), sample_t'(0), 32'd0);
		send_sample(sample_t'(32767), sample_t'(-32768), sample_t'(-1), 32'd10);
		send_sample(sample_t'(0), sample_t'(0), sample_t'(32767), 32'd20);
		settle();
		plan_reg(REG_FILTER_ALPHA, 16'h01FF);   // saturates, filter equals the sample
		commit_regs();
		send_sample(sample_t'(-32768), sample_t'(-32768), sample_t'(-32768), 32'd30);
		settle();
		plan_reg(REG_FILTER_ALPHA, 16'h0000);   // filter frozen
		commit_regs();
		send_sample(sample_t'(32767), sample_t'(32767), sample_t'(32767), 32'd40);
		settle();
	endtask

	// every quadrant, ties between the axes and the untilted case
	task automatic test_quadrants();
		plan_reg(REG_MANUAL_ROTATION, 16'(ROT_0));
		plan_reg(REG_AUTO_ENABLE, 16'd1);
		plan_reg(REG_FILTER_ALPHA, 16'd256);
		plan_reg(REG_STABLE_TIME, 16'd0);
		plan_reg(REG_TILT_THRESHOLD, 16'd2048);
		commit_regs();
		// each pair: first sets the candidate, second switches at zero debounce
		repeat (2) send_sample(sample_t'(0), sample_t'(-ONE_G), sample_t'(0), 32'd100);
		repeat (2) send_sample(sample_t'(-ONE_G), sample_t'(0), sample_t'(0), 32'd110);
		repeat (2) send_sample(sample_t'(0), sample_t'(ONE_G), sample_t'(0), 32'd120);
		repeat (2) send_sample(sample_t'(ONE_G), sample_t'(0), sample_t'(0), 32'd130);
		settle();
		// zero threshold: all-zero reading is tilted, zero x counts as not positive
		plan_reg(REG_TILT_THRESHOLD, 16'd0);
		commit_regs();
		repeat (2) send_sample(sample_t'(0), sample_t'(0), sample_t'(0), 32'd140);
		send_sample(sample_t'(ONE_G), sample_t'(ONE_G), sample_t'(0), 32'd150);
		send_sample(sample_t'(-ONE_G), sample_t'(ONE_G), sample_t'(0), 32'd160);
		settle();
		// small reading under the threshold, candidate falls back
		plan_reg(REG_TILT_THRESHOLD, 16'd2048);
		commit_regs();
		send_sample(sample_t'(100), sample_t'(-100), sample_t'(5), 32'd170);
		settle();
	endtask

	// debounce time measured across the timestamp wrap, and the longest setting
	task automatic test_debounce();
		logic [31:0] t0;
		t0 = 32'hFFFF_FF00;
		plan_reg(REG_MANUAL_ROTATION, 16'(ROT_0));
		plan_reg(REG_AUTO_ENABLE, 16'd1);
		plan_reg(REG_STABLE_TIME, 16'd350);
		commit_regs();
		send_sample(sample_t'(0), sample_t'(ONE_G), sample_t'(0), t0);
		send_sample(sample_t'(0), sample_t'(ONE_G), sample_t'(0), t0 + 32'd349);
		send_sample(sample_t'(0), sample_t'(ONE_G), sample_t'(0), t0 + 32'd350);
		settle();
		plan_reg(REG_STABLE_TIME, 16'hFFFF);
		commit_regs();
		send_sample(sample_t'(-ONE_G), sample_t'(0), sample_t'(0), 32'd1000);
		send_sample(sample_t'(-ONE_G), sample_t'(0), sample_t'(0), 32'd1000 + 32'd65535);
		settle();
	endtask

	// manual rotation stops auto mode, filter and tilt flag still follow
	task automatic test_manual_mode();
		plan_reg(REG_MANUAL_ROTATION, 16'(ROT_90));
		plan_reg(REG_STABLE_TIME, 16'd0);
		commit_regs();
		send_sample(sample_t'(ONE_G), sample_t'(0), sample_t'(0), 32'd5000);
		settle();
		plan_reg(REG_AUTO_ENABLE, 16'd0);
		commit_regs();
		send_sample(sample_t'(ONE_G), sample_t'(0), sample_t'(0), 32'd9000);
		settle();
		plan_reg(REG_AUTO_ENABLE, 16'd1);
		commit_regs();
		repeat (2) send_sample(sample_t'(ONE_G), sample_t'(0), sample_t'(0), 32'd9100);
		settle();
	endtask

	// out-of-range data keeps the low bits, indexes past the list do nothing
	task automatic test_register_bounds();
		logic [CFG_IDX_W-1:0] idx;
		for (int i = FIRST_SPARE_REG; i <= LAST_SPARE_REG; i++) begin
			idx = i[CFG_IDX_W-1:0];
			plan_reg(idx, 16'hFFFF);
		end
		plan_reg(REG_TILT_THRESHOLD, 16'hFFFF);
		plan_reg(REG_MANUAL_ROTATION, 16'hFFFF);
		commit_regs();
		send_sample(sample_t'(-32768), sample_t'(32767), sample_t'(0), 32'd9200);
		settle();
	endtask

	// receiver holds off while samples keep coming, so the input side stalls
	task automatic test_backpressure();
		plan_reg(REG_TILT_THRESHOLD, 16'd2048);
		plan_reg(REG_FILTER_ALPHA, 16'd128);
		plan_reg(REG_STABLE_TIME, 16'd100);
		plan_reg(REG_AUTO_ENABLE, 16'd1);
		commit_regs();
		pacing_on = 1'b0;
		hold_go   = 1'b1;
		lean_run(ROT_270, 24, 60);
		// sender pauses until the whole backlog has drained
		settle();
		pacing_on = 1'b1;
	endtask

	// mostly orientation runs with random content, some plain noise
	task automatic test_random();
		int phase_start;
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			case (p)
				0: begin
					plan_reg(REG_FILTER_ALPHA, 16'd256);
					plan_reg(REG_TILT_THRESHOLD, 16'd0);
					plan_reg(REG_STABLE_TIME, 16'd0);
				end
				1: begin
					plan_reg(REG_FILTER_ALPHA, 16'd0);
					plan_reg(REG_TILT_THRESHOLD, 16'h7FFF);
					plan_reg(REG_STABLE_TIME, 16'hFFFF);
				end
				default: begin
					plan_reg(REG_FILTER_ALPHA, ($urandom_range(0, 4) == 0) ?
						16'($urandom_range(257, 511)) : 16'($urandom_range(16, 256)));
					plan_reg(REG_TILT_THRESHOLD, 16'($urandom_range(300, 5000)));
					plan_reg(REG_STABLE_TIME, 16'($urandom_range(0, 600)));
				end
			endcase
			// sometimes start from a manual rotation before going automatic
			if ($urandom_range(0, 2) == 0)
				plan_reg(REG_MANUAL_ROTATION, 16'($urandom_range(0, 3)));
			plan_reg(REG_AUTO_ENABLE, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'd1);
			commit_regs();
			phase_start = samples_sent;
			while (samples_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					noise_sample();
				else
					lean_run(2'($urandom_range(0, 3)), $urandom_range(3, 12), 120);
			end
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// clock, reset and the test sequence
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n      <= 1'b0;
		smp.valid   <= 1'b0;
		smp.accel_x <= '0;
		smp.accel_y <= '0;
		smp.accel_z <= '0;
		smp.now_ms  <= '0;
		cfg.valid   <= 1'b0;
		cfg.index   <= '0;
		cfg.data    <= '0;
		// predictor starts from the reset state
		filt_x       = '0;
		filt_y       = '0;
		filt_z       = '0;
		filt_loaded  = 1'b0;
		cur_quad     = ROT_0;
		cand_quad    = ROT_0;
		cand_since   = '0;
		auto_on      = 1'b1;
		manual_rot   = ROT_0;
		threshold    = THR_RESET;
		alpha        = ALPHA_RESET;
		hold_ms      = STABLE_RESET;
		mismatches   = 0;
		samples_sent = 0;
		ms_now       = $urandom;
		pacing_on    = 1'b1;
		burst_left   = 0;
		hold_go      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_filter_load();
		test_quadrants();
		test_debounce();
		test_manual_mode();
		test_register_bounds();
		test_backpressure();
		test_random();

		settle();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending.size() == 0)
			$display("tb_tilt_rotation_detector passed");
		else
			$display("tb_tilt_rotation_detector failed");
		$finish;
	end

	// receiver: stall rate changes now and then, including stretches with none
	initial begin
		res.ready <= 1'b0;
		hold_left = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go   = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				res.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// every result transfer is compared with the oldest expectation
	always @(posedge clk) begin : check_results
		orient_t want;
		orient_t got;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			got.rotation = res.rotation;
			got.changed  = res.rotation_changed;
			got.tilted   = res.tilted;
			got.fx       = res.filtered_x;
			got.fy       = res.filtered_y;
			got.fz       = res.filtered_z;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: unexpected result rot=%0d chg=%0b tilt=%0b f=%0d/%0d/%0d",
						$realtime, got.rotation, got.changed, got.tilted,
						got.fx, got.fy, got.fz);
			end else begin
				want = pending.pop_front();
				if (got.rotation !== want.rotation || got.changed !== want.changed ||
						got.tilted !== want.tilted || got.fx !== want.fx ||
						got.fy !== want.fy || got.fz !== want.fz) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("%0t: mismatch exp rot=%0d chg=%0b tilt=%0b f=%0d/%0d/%0d",
							$realtime, want.rotation, want.changed, want.tilted,
							want.fx, want.fy, want.fz);
						$display("%0t:          got rot=%0d chg=%0b tilt=%0b f=%0d/%0d/%0d",
							$realtime, got.rotation, got.changed, got.tilted,
							got.fx, got.fy, got.fz);
					end
				end
			end
		end
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_tilt_rotation_detector failed");
			$finish;
		end
	end

endmodule
